FILE: hw/rtl/otcb_pkg.sv
package otcb_pkg;

  localparam int RING_WORDS = 32768;
  localparam int BUCKETS    = 1024;

  localparam int RING_AW  = $clog2(RING_WORDS);
  localparam int CNT_W    = $clog2(BUCKETS + 1);
  localparam int LINK_W   = 24;
  localparam int COUNT_W  = 8;
  localparam int WORD_W   = LINK_W + COUNT_W;
  localparam int OP_W     = 3;
  localparam int DEPTH_W  = 10;
  localparam int RIDX_W   = 15;

  // Link value that terminates a list.
  localparam logic [LINK_W-1:0] LINK_END = {LINK_W{1'b1}};

  typedef logic [RING_AW-1:0] ring_idx_t;

  typedef enum logic [OP_W-1:0] {
    OP_NEW_BLOCK  = 3'd0,
    OP_BEGIN_PRIM = 3'd1,
    OP_DATA       = 3'd2,
    OP_FLUSH      = 3'd3,
    OP_READ       = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    STEP_NONE,
    STEP_OPEN_SET,
    STEP_SWEEP,
    STEP_BKT_HDR,
    STEP_BKT_LINK,
    STEP_FR_HDR,
    STEP_FR_RD,
    STEP_FR_WR
  } step_e;

  typedef struct packed {
    logic  accept;
    step_e step;
  } cmd_t;

  typedef struct packed {
    logic chain_live;
    logic sweep_last;
  } status_t;

endpackage

FILE: hw/rtl/otcb_ctrl.sv
module otcb_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [otcb_pkg::OP_W-1:0] operation_i,
  input  logic                      draw_in_front_i,
  input  otcb_pkg::status_t         sts_i,
  output otcb_pkg::cmd_t            cmd_o,
  output logic                      busy_o,
  output logic                      done_o
);
  import otcb_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_OPEN_SET = 8'b0000_0010,
    S_SWEEP    = 8'b0000_0100,
    S_BKT_HDR  = 8'b0000_1000,
    S_BKT_LINK = 8'b0001_0000,
    S_FR_HDR   = 8'b0010_0000,
    S_FR_RD    = 8'b0100_0000,
    S_FR_WR    = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic   done_q, done_d;
  logic   accept;

  assign accept = start_i && (state_q == S_IDLE);

  always_comb begin
    state_d      = state_q;
    done_d       = 1'b0;
    cmd_o.accept = accept;
    cmd_o.step   = STEP_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (op_e'(operation_i))
            OP_NEW_BLOCK:  state_d = S_OPEN_SET;
            OP_BEGIN_PRIM: state_d = draw_in_front_i ? S_FR_HDR : S_BKT_HDR;
            OP_FLUSH: begin
              if (sts_i.chain_live) begin
                state_d = S_OPEN_SET;
              end else begin
                done_d = 1'b1;
              end
            end
            default:       done_d = 1'b1;
          endcase
        end
      end
      S_OPEN_SET: begin
        cmd_o.step = STEP_OPEN_SET;
        state_d    = S_SWEEP;
      end
      S_SWEEP: begin
        cmd_o.step = STEP_SWEEP;
        if (sts_i.sweep_last) begin
          state_d = S_IDLE;
          done_d  = 1'b1;
        end
      end
      S_BKT_HDR: begin
        cmd_o.step = STEP_BKT_HDR;
        state_d    = S_BKT_LINK;
      end
      S_BKT_LINK: begin
        cmd_o.step = STEP_BKT_LINK;
        state_d    = S_IDLE;
        done_d     = 1'b1;
      end
      S_FR_HDR: begin
        cmd_o.step = STEP_FR_HDR;
        state_d    = S_FR_RD;
      end
      S_FR_RD: begin
        cmd_o.step = STEP_FR_RD;
        state_d    = S_FR_WR;
      end
      S_FR_WR: begin
        cmd_o.step = STEP_FR_WR;
        state_d    = S_IDLE;
        done_d     = 1'b1;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;

endmodule

FILE: hw/rtl/otcb_dp.sv
module otcb_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  otcb_pkg::cmd_t               cmd_i,
  input  logic                         cfg_we_i,
  input  logic [otcb_pkg::LINK_W-1:0]  cfg_wdata_i,
  input  logic [otcb_pkg::OP_W-1:0]    operation_i,
  input  logic [otcb_pkg::COUNT_W-1:0] word_count_i,
  input  logic [otcb_pkg::DEPTH_W-1:0] depth_i,
  input  logic                         draw_in_front_i,
  input  logic [otcb_pkg::WORD_W-1:0]  data_word_i,
  input  logic [otcb_pkg::RIDX_W-1:0]  read_index_i,
  output otcb_pkg::status_t            sts_o,
  output logic [otcb_pkg::WORD_W-1:0]  read_data_o,
  output logic                         send_valid_o,
  output logic [otcb_pkg::LINK_W-1:0]  send_address_o
);
  import otcb_pkg::*;

  function automatic logic [LINK_W-1:0] bus_addr(input logic [LINK_W-1:0] base,
                                                 input ring_idx_t idx);
    return base + LINK_W'({idx, 2'b00});
  endfunction

  logic [WORD_W-1:0]  ring_q [RING_WORDS];
  logic [WORD_W-1:0]  rdata_q;

  logic [LINK_W-1:0]  base_q;
  ring_idx_t          be_q, table_q, chain_q, front_q, fill_q;
  ring_idx_t          header_q, bucket_q, wr_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [LINK_W-1:0]  link_q;
  logic [COUNT_W-1:0] count_q;
  logic               res_read_q;
  logic               send_valid_q;
  logic [LINK_W-1:0]  send_addr_q;

  ring_idx_t          open_wrap, open_be;
  logic [RING_AW:0]   prim_sum;
  logic               prim_ovf;
  ring_idx_t          prim_cnt1, prim_be, prim_hdr, prim_fill;
  ring_idx_t          bkt_idx;
  logic               fill_open;

  logic               mem_we, mem_re;
  ring_idx_t          mem_waddr, mem_raddr;
  logic [WORD_W-1:0]  mem_wdata;

  // A new block ends one table past the old end, restarting near the ring
  // base when that would wrap.
  assign open_wrap = be_q + ring_idx_t'(BUCKETS + 1);
  assign open_be   = (open_wrap < ring_idx_t'(BUCKETS + 1)) ? ring_idx_t'(BUCKETS + 1)
                                                            : open_wrap;

  assign prim_sum  = {1'b0, be_q} + (RING_AW+1)'(word_count_i) + (RING_AW+1)'(1);
  assign prim_ovf  = prim_sum[RING_AW];
  assign prim_cnt1 = ring_idx_t'(word_count_i) + ring_idx_t'(1);
  assign prim_be   = prim_ovf ? prim_cnt1 : prim_sum[RING_AW-1:0];
  assign prim_hdr  = prim_ovf ? '0 : be_q;
  assign prim_fill = prim_ovf ? ring_idx_t'(1) : be_q + ring_idx_t'(1);

  assign bkt_idx   = table_q + ring_idx_t'(depth_i % BUCKETS);
  assign fill_open = (fill_q != be_q);

  assign sts_o.chain_live = (chain_q != (be_q - ring_idx_t'(1)));
  assign sts_o.sweep_last = (cnt_q == CNT_W'(BUCKETS));

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = '0;
    unique case (cmd_i.step)
      STEP_NONE: begin
        if (cmd_i.accept) begin
          if (operation_i == OP_DATA && fill_open) begin
            mem_we    = 1'b1;
            mem_waddr = fill_q;
            mem_wdata = data_word_i;
          end
          if (operation_i == OP_READ) begin
            mem_re    = 1'b1;
            mem_raddr = ring_idx_t'(read_index_i % RING_WORDS);
          end
          if (operation_i == OP_BEGIN_PRIM && !draw_in_front_i) begin
            mem_re    = 1'b1;
            mem_raddr = bkt_idx;
          end
        end
      end
      STEP_OPEN_SET: ;
      STEP_SWEEP: begin
        // The first word is the terminator; each table word then links down.
        mem_we    = 1'b1;
        mem_waddr = wr_q;
        mem_wdata = (cnt_q == '0) ? {{COUNT_W{1'b0}}, LINK_END}
                                  : {{COUNT_W{1'b0}}, link_q};
      end
      STEP_BKT_HDR: begin
        mem_we    = 1'b1;
        mem_waddr = header_q;
        mem_wdata = rdata_q | {count_q, {LINK_W{1'b0}}};
      end
      STEP_BKT_LINK: begin
        mem_we    = 1'b1;
        mem_waddr = bucket_q;
        mem_wdata = {{COUNT_W{1'b0}}, bus_addr(base_q, header_q)};
      end
      STEP_FR_HDR: begin
        mem_we    = 1'b1;
        mem_waddr = header_q;
        mem_wdata = {count_q, LINK_END};
      end
      STEP_FR_RD: begin
        mem_re    = 1'b1;
        mem_raddr = front_q;
      end
      STEP_FR_WR: begin
        mem_we    = 1'b1;
        mem_waddr = front_q;
        mem_wdata = {rdata_q[WORD_W-1:LINK_W], bus_addr(base_q, header_q)};
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ring_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= ring_q[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q       <= '0;
      be_q         <= '0;
      table_q      <= '0;
      chain_q      <= '0;
      front_q      <= '0;
      fill_q       <= '0;
      header_q     <= '0;
      bucket_q     <= '0;
      wr_q         <= '0;
      cnt_q        <= '0;
      link_q       <= '0;
      count_q      <= '0;
      res_read_q   <= 1'b0;
      send_valid_q <= 1'b0;
      send_addr_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        base_q <= cfg_wdata_i;
      end
      unique case (cmd_i.step)
        STEP_NONE: begin
          if (cmd_i.accept) begin
            res_read_q   <= (operation_i == OP_READ);
            send_valid_q <= 1'b0;
            send_addr_q  <= '0;
            unique case (op_e'(operation_i))
              OP_NEW_BLOCK: be_q <= open_be;
              OP_BEGIN_PRIM: begin
                be_q     <= prim_be;
                header_q <= prim_hdr;
                fill_q   <= prim_fill;
                count_q  <= word_count_i;
                bucket_q <= bkt_idx;
              end
              OP_DATA: begin
                if (fill_open) begin
                  fill_q <= fill_q + ring_idx_t'(1);
                end
              end
              OP_FLUSH: begin
                if (sts_o.chain_live) begin
                  send_valid_q <= 1'b1;
                  send_addr_q  <= bus_addr(base_q, chain_q);
                  be_q         <= open_be;
                end
              end
              default: ;
            endcase
          end
        end
        STEP_OPEN_SET: begin
          table_q <= be_q - ring_idx_t'(BUCKETS);
          chain_q <= be_q - ring_idx_t'(1);
          front_q <= be_q - ring_idx_t'(BUCKETS + 1);
          fill_q  <= be_q;
          wr_q    <= be_q - ring_idx_t'(BUCKETS + 1);
          cnt_q   <= '0;
        end
        STEP_SWEEP: begin
          wr_q   <= wr_q + ring_idx_t'(1);
          cnt_q  <= cnt_q + CNT_W'(1);
          link_q <= bus_addr(base_q, wr_q);
        end
        STEP_FR_WR: front_q <= header_q;
        default: ;
      endcase
    end
  end

  assign read_data_o    = res_read_q ? rdata_q : '0;
  assign send_valid_o   = send_valid_q;
  assign send_address_o = send_addr_q;

endmodule

FILE: hw/rtl/ordering_table_chain_builder_core.sv
// Builds a DMA display list in an on-chip ring of 32768 words. A request is
// taken when start is high and busy is low; its single result is shown for
// exactly one cycle with done_o high, and the receiver cannot stall it. Data
// words, reads and unused operations return their result in the next cycle,
// where a new request is already taken. Beginning a primitive reads the
// bucket word, writes the header and then the bucket link when linking into
// a bucket, or writes the header, reads the front word and writes it back
// when appending to the front list. A new block, and a flush that sends a
// chain, open a new table and then write the terminator and every table word
// one per cycle. The ring has no reset and needs no clearing pass; the base
// address may be written only while the block is idle.
module ordering_table_chain_builder_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  output logic                         done_o,
  input  logic                         cfg_we_i,
  input  logic [otcb_pkg::LINK_W-1:0]  cfg_wdata_i,
  input  logic [otcb_pkg::OP_W-1:0]    operation_i,
  input  logic [otcb_pkg::COUNT_W-1:0] word_count_i,
  input  logic [otcb_pkg::DEPTH_W-1:0] depth_i,
  input  logic                         draw_in_front_i,
  input  logic [otcb_pkg::WORD_W-1:0]  data_word_i,
  input  logic [otcb_pkg::RIDX_W-1:0]  read_index_i,
  output logic [otcb_pkg::WORD_W-1:0]  read_data_o,
  output logic                         send_valid_o,
  output logic [otcb_pkg::LINK_W-1:0]  send_address_o
);
  import otcb_pkg::*;

  cmd_t    cmd;
  status_t sts;

  otcb_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .operation_i    (operation_i),
    .draw_in_front_i(draw_in_front_i),
    .sts_i          (sts),
    .cmd_o          (cmd),
    .busy_o         (busy),
    .done_o         (done_o)
  );

  otcb_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .operation_i    (operation_i),
    .word_count_i   (word_count_i),
    .depth_i        (depth_i),
    .draw_in_front_i(draw_in_front_i),
    .data_word_i    (data_word_i),
    .read_index_i   (read_index_i),
    .sts_o          (sts),
    .read_data_o    (read_data_o),
    .send_valid_o   (send_valid_o),
    .send_address_o (send_address_o)
  );

endmodule

FILE: hw/rtl/otcb_checker.sv
module otcb_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        start,
  input logic                        busy,
  input logic                        done_o,
  input logic [otcb_pkg::OP_W-1:0]   operation_i,
  input logic [otcb_pkg::WORD_W-1:0] read_data_o,
  input logic                        send_valid_o
);
  import otcb_pkg::*;

  // Data and read requests finish in the next cycle and leave the block free.
  a_quick_ops : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (operation_i == OP_DATA || operation_i == OP_READ)
    |=> done_o && !busy)
    else $error("quick request did not finish in one cycle");

  // A new block always sweeps the table before reporting.
  a_new_block_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && operation_i == OP_NEW_BLOCK |=> busy && !done_o)
    else $error("new block finished without a table sweep");

  // Leaving a multi-cycle request always delivers its result.
  a_busy_fall_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("busy dropped without a result");

  // A sent chain is never a read result.
  a_send_no_read : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && send_valid_o |-> read_data_o == '0)
    else $error("flush result carries read data");

endmodule

bind ordering_table_chain_builder_core otcb_checker u_otcb_checker (.*);
